FILE: rtl/core/free_window_table_defines.svh
// ----------------------------------------------------------------------------
// Free window table assertion macros
// Shared concurrent assertion wrappers, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FREE_WINDOW_TABLE_DEFINES_SVH
`define FREE_WINDOW_TABLE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FWT_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("free window table check failed");

// A condition in one cycle that forces another in the next cycle.
`define FWT_CHECK_NEXT(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("free window table sequence check failed");

`endif

FILE: rtl/core/fwt_pkg.sv
// ----------------------------------------------------------------------------
// Free window table package
// Shared constants, codes and types of the free window table.
// ----------------------------------------------------------------------------
package fwt_pkg;

   localparam int DEF_DEPTH       = 16;
   localparam int DEF_TIME_BITS   = 48;
   localparam int DEF_DEVICE_BITS = 8;

   localparam int TRK_BITS  = 6;
   localparam int POS_BITS  = 6;
   localparam int IDX_BITS  = 6;
   localparam int TC_BITS   = 7;
   localparam int CMP_W     = 7;

   localparam logic [2:0] MODE_REBUILD = 3'd0;
   localparam logic [2:0] MODE_INSERT  = 3'd1;
   localparam logic [2:0] MODE_REMOVE  = 3'd2;
   localparam logic [2:0] MODE_CONTAIN = 3'd3;
   localparam logic [2:0] MODE_DEVICE  = 3'd4;
   localparam logic [2:0] MODE_OVERLAP = 3'd5;
   localparam logic [2:0] MODE_MULTI   = 3'd6;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NONE   = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_BADIDX = 2'd3;

   localparam logic [2:0] ADDR_TRACKS = 3'd0;
   localparam logic [2:0] ADDR_HOST   = 3'd4;

   localparam logic [TC_BITS-1:0] TRACKS_RESET = 7'd4;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef struct packed {
      logic shift;
      logic rebuild;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/free_window_table.sv
// ----------------------------------------------------------------------------
// Free window table
// Ordered table of free time windows held in a rotating chain of cells.
// ----------------------------------------------------------------------------
// The table lives in a chain of DEPTH cells that rotates toward cell 0; every
// search, insert and remove walks the whole chain once, one entry per cycle
// whenever the result side is not holding rsp_ready low while a result waits.
// Rebuild, a full-table insert, a bad remove index and the unused mode skip
// the walk. Results of one item come out in table order; the one that closes
// the item carries last. Registers are to be written only while the block is
// idle (track_count at 0x0, host_id at 0x4); this binds the user, as the block
// itself does not enforce it.
module free_window_table #(
   parameter int DEPTH       = fwt_pkg::DEF_DEPTH,
   parameter int TIME_BITS   = fwt_pkg::DEF_TIME_BITS,
   parameter int DEVICE_BITS = fwt_pkg::DEF_DEVICE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_mode,
   input  logic [TIME_BITS-1:0]          req_time_start,
   input  logic [TIME_BITS-1:0]          req_time_stop,
   input  logic [DEVICE_BITS-1:0]        req_device,
   input  logic [fwt_pkg::TRK_BITS-1:0]  req_track,
   input  logic [fwt_pkg::IDX_BITS-1:0]  req_index,
   input  logic [fwt_pkg::IDX_BITS-1:0]  req_task_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [fwt_pkg::POS_BITS-1:0]  rsp_position,
   output logic [TIME_BITS-1:0]          rsp_win_start,
   output logic [TIME_BITS-1:0]          rsp_win_stop,
   output logic [DEVICE_BITS-1:0]        rsp_win_device,
   output logic [fwt_pkg::TRK_BITS-1:0]  rsp_win_track,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

`include "free_window_table_defines.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [fwt_pkg::CMP_W-1:0] DEPTH_C = fwt_pkg::CMP_W'(DEPTH);
   localparam logic [CNT_W-1:0] K_LAST = CNT_W'(DEPTH - 1);

   // Cell chain
   logic [TIME_BITS-1:0]         c_begin [DEPTH];
   logic [TIME_BITS-1:0]         c_end   [DEPTH];
   logic [DEVICE_BITS-1:0]       c_dev   [DEPTH];
   logic [fwt_pkg::TRK_BITS-1:0] c_trk   [DEPTH];

   logic [TIME_BITS-1:0]         tail_begin, tail_end;
   logic [DEVICE_BITS-1:0]       tail_dev;
   logic [fwt_pkg::TRK_BITS-1:0] tail_trk;
   fwt_pkg::cell_ctrl_type       cell_ctrl;

   // Control and operand registers
   fwt_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [fwt_pkg::TC_BITS-1:0]  tc_ff, tc_in;
   logic [7:0]                   host_ff, host_in;
   logic [2:0]                   mode_ff, mode_in;
   logic [TIME_BITS-1:0]         qs_ff, qs_in, qf_ff, qf_in;
   logic [DEVICE_BITS-1:0]       qdev_ff, qdev_in;
   logic [fwt_pkg::TRK_BITS-1:0] qtrk_ff, qtrk_in;
   logic [fwt_pkg::IDX_BITS-1:0] qidx_ff, qidx_in;
   logic [fwt_pkg::TC_BITS-1:0]  lim_ff, lim_in, taken_ff, taken_in;
   logic                         found_ff, found_in;
   logic [fwt_pkg::TRK_BITS-1:0] sel_ff, sel_in;

   // Entry pushed aside by an insert
   logic [TIME_BITS-1:0]         car_begin_ff, car_begin_in, car_end_ff, car_end_in;
   logic [DEVICE_BITS-1:0]       car_dev_ff, car_dev_in;
   logic [fwt_pkg::TRK_BITS-1:0] car_trk_ff, car_trk_in;

   // Pending result, released once the next one or the end of the walk is known
   logic                         pend_ff, pend_in;
   logic [1:0]                   pst_ff, pst_in;
   logic [fwt_pkg::POS_BITS-1:0] ppos_ff, ppos_in;
   logic [TIME_BITS-1:0]         pbeg_ff, pbeg_in, pend_t_ff, pend_t_in;
   logic [DEVICE_BITS-1:0]       pdev_ff, pdev_in;
   logic [fwt_pkg::TRK_BITS-1:0] ptrk_ff, ptrk_in;

   // Output register
   logic                         rv_ff, rv_in;
   logic [1:0]                   rst_ff, rst_in;
   logic [fwt_pkg::POS_BITS-1:0] rpos_ff, rpos_in;
   logic [TIME_BITS-1:0]         rbeg_ff, rbeg_in, rend_ff, rend_in;
   logic [DEVICE_BITS-1:0]       rdev_ff, rdev_in;
   logic [fwt_pkg::TRK_BITS-1:0] rtrk_ff, rtrk_in;
   logic                         rlast_ff, rlast_in;

   logic                         out_free;
   logic [fwt_pkg::TC_BITS-1:0]  tsat;
   logic [fwt_pkg::CMP_W-1:0]    kc, cntc, idxc;
   logic                         in_tbl, cont, ovl, hit, ins_here;
   logic                         csr_wr;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi < DEPTH - 1) begin : g_mid
            fwt_cell #(.TIME_BITS(TIME_BITS), .DEVICE_BITS(DEVICE_BITS)) u_cell (
               .clock(clock), .ctrl(cell_ctrl),
               .in_begin(c_begin[gi+1]), .in_end(c_end[gi+1]),
               .in_dev(c_dev[gi+1]), .in_trk(c_trk[gi+1]),
               .rb_dev(DEVICE_BITS'(host_ff)), .rb_trk(fwt_pkg::TRK_BITS'(gi)),
               .out_begin(c_begin[gi]), .out_end(c_end[gi]),
               .out_dev(c_dev[gi]), .out_trk(c_trk[gi]));
         end else begin : g_tail
            fwt_cell #(.TIME_BITS(TIME_BITS), .DEVICE_BITS(DEVICE_BITS)) u_cell (
               .clock(clock), .ctrl(cell_ctrl),
               .in_begin(tail_begin), .in_end(tail_end),
               .in_dev(tail_dev), .in_trk(tail_trk),
               .rb_dev(DEVICE_BITS'(host_ff)), .rb_trk(fwt_pkg::TRK_BITS'(gi)),
               .out_begin(c_begin[gi]), .out_end(c_end[gi]),
               .out_dev(c_dev[gi]), .out_trk(c_trk[gi]));
         end
      end
   endgenerate

   assign tsat     = (fwt_pkg::CMP_W'(tc_ff) > DEPTH_C) ? fwt_pkg::TC_BITS'(DEPTH_C) : tc_ff;
   assign out_free = !rv_ff || rsp_ready;
   assign kc       = fwt_pkg::CMP_W'(k_ff);
   assign cntc     = fwt_pkg::CMP_W'(cnt_ff);
   assign idxc     = fwt_pkg::CMP_W'(qidx_ff);
   assign in_tbl   = kc < cntc;
   assign cont     = (c_end[0] >= qs_ff) && (c_begin[0] <= qs_ff) && (c_end[0] >= qf_ff);
   assign ovl      = (c_begin[0] < qf_ff) && (c_end[0] > qs_ff);
   assign ins_here = !found_ff && ((kc == cntc) || (in_tbl && (qf_ff < c_end[0])));

   always_comb begin
      case (mode_ff)
         fwt_pkg::MODE_INSERT:  hit = ins_here;
         fwt_pkg::MODE_REMOVE:  hit = (kc == idxc);
         fwt_pkg::MODE_CONTAIN: hit = in_tbl && !found_ff && cont;
         fwt_pkg::MODE_DEVICE:  hit = in_tbl && !found_ff && cont && (c_dev[0] == qdev_ff);
         fwt_pkg::MODE_OVERLAP: hit = in_tbl && ovl && (!found_ff || (c_trk[0] == sel_ff));
         fwt_pkg::MODE_MULTI:   hit = in_tbl && cont && (taken_ff < lim_ff);
         default:               hit = 1'b0;
      endcase
   end

   // What enters the far end of the chain during a walk.
   always_comb begin
      tail_begin = c_begin[0];
      tail_end   = c_end[0];
      tail_dev   = c_dev[0];
      tail_trk   = c_trk[0];
      if (mode_ff == fwt_pkg::MODE_INSERT) begin
         if (ins_here) begin
            tail_begin = qs_ff;
            tail_end   = qf_ff;
            tail_dev   = qdev_ff;
            tail_trk   = qtrk_ff;
         end else if (found_ff) begin
            tail_begin = car_begin_ff;
            tail_end   = car_end_ff;
            tail_dev   = car_dev_ff;
            tail_trk   = car_trk_ff;
         end
      end else if (mode_ff == fwt_pkg::MODE_REMOVE && kc >= idxc) begin
         // From the removed entry on, each slot takes its successor.
         tail_begin = c_begin[1];
         tail_end   = c_end[1];
         tail_dev   = c_dev[1];
         tail_trk   = c_trk[1];
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      qs_in     = qs_ff;
      qf_in     = qf_ff;
      qdev_in   = qdev_ff;
      qtrk_in   = qtrk_ff;
      qidx_in   = qidx_ff;
      lim_in    = lim_ff;
      taken_in  = taken_ff;
      found_in  = found_ff;
      sel_in    = sel_ff;
      car_begin_in = car_begin_ff;
      car_end_in   = car_end_ff;
      car_dev_in   = car_dev_ff;
      car_trk_in   = car_trk_ff;
      pend_in   = pend_ff;
      pst_in    = pst_ff;
      ppos_in   = ppos_ff;
      pbeg_in   = pbeg_ff;
      pend_t_in = pend_t_ff;
      pdev_in   = pdev_ff;
      ptrk_in   = ptrk_ff;
      rv_in     = rv_ff && !rsp_ready;
      rst_in    = rst_ff;
      rpos_in   = rpos_ff;
      rbeg_in   = rbeg_ff;
      rend_in   = rend_ff;
      rdev_in   = rdev_ff;
      rtrk_in   = rtrk_ff;
      rlast_in  = rlast_ff;
      cell_ctrl = '0;

      case (state_ff)
         fwt_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               qs_in     = req_time_start;
               qf_in     = req_time_stop;
               qdev_in   = req_device;
               qtrk_in   = req_track;
               qidx_in   = req_index;
               k_in      = '0;
               taken_in  = '0;
               found_in  = 1'b0;
               pend_in   = 1'b0;
               pst_in    = fwt_pkg::STATUS_OK;
               ppos_in   = '0;
               pbeg_in   = '0;
               pend_t_in = '0;
               pdev_in   = '0;
               ptrk_in   = '0;
               state_in  = fwt_pkg::ST_SCAN;
               case (req_mode)
                  fwt_pkg::MODE_REBUILD: begin
                     cell_ctrl.rebuild = 1'b1;
                     cnt_in   = CNT_W'(tsat);
                     pend_in  = 1'b1;
                     state_in = fwt_pkg::ST_FLUSH;
                  end
                  fwt_pkg::MODE_INSERT: begin
                     if (cntc == DEPTH_C) begin
                        pend_in  = 1'b1;
                        pst_in   = fwt_pkg::STATUS_FULL;
                        state_in = fwt_pkg::ST_FLUSH;
                     end
                  end
                  fwt_pkg::MODE_REMOVE: begin
                     if (fwt_pkg::CMP_W'(req_index) >= cntc) begin
                        pend_in  = 1'b1;
                        pst_in   = fwt_pkg::STATUS_BADIDX;
                        state_in = fwt_pkg::ST_FLUSH;
                     end
                  end
                  fwt_pkg::MODE_MULTI: begin
                     lim_in = (fwt_pkg::TC_BITS'(req_task_count) < tsat) ?
                              fwt_pkg::TC_BITS'(req_task_count) : tsat;
                  end
                  fwt_pkg::MODE_CONTAIN, fwt_pkg::MODE_DEVICE, fwt_pkg::MODE_OVERLAP: begin
                     state_in = fwt_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = fwt_pkg::ST_FLUSH;
                  end
               endcase
            end
         end
         fwt_pkg::ST_SCAN: begin
            if (out_free) begin
               cell_ctrl.shift = 1'b1;
               car_begin_in = c_begin[0];
               car_end_in   = c_end[0];
               car_dev_in   = c_dev[0];
               car_trk_in   = c_trk[0];
               k_in = k_ff + 1'b1;
               if (hit) begin
                  // A new hit proves the pending one was not the last.
                  if (pend_ff) begin
                     rv_in    = 1'b1;
                     rst_in   = pst_ff;
                     rpos_in  = ppos_ff;
                     rbeg_in  = pbeg_ff;
                     rend_in  = pend_t_ff;
                     rdev_in  = pdev_ff;
                     rtrk_in  = ptrk_ff;
                     rlast_in = 1'b0;
                  end
                  pend_in  = 1'b1;
                  pst_in   = fwt_pkg::STATUS_OK;
                  ppos_in  = fwt_pkg::POS_BITS'(k_ff);
                  found_in = 1'b1;
                  sel_in   = c_trk[0];
                  taken_in = taken_ff + 1'b1;
                  if (mode_ff == fwt_pkg::MODE_INSERT) begin
                     pbeg_in   = qs_ff;
                     pend_t_in = qf_ff;
                     pdev_in   = qdev_ff;
                     ptrk_in   = qtrk_ff;
                     cnt_in    = cnt_ff + 1'b1;
                  end else begin
                     pbeg_in   = c_begin[0];
                     pend_t_in = c_end[0];
                     pdev_in   = c_dev[0];
                     ptrk_in   = c_trk[0];
                     if (mode_ff == fwt_pkg::MODE_REMOVE) begin
                        cnt_in = cnt_ff - 1'b1;
                     end
                  end
               end
               if (k_ff == K_LAST) begin
                  state_in = fwt_pkg::ST_FLUSH;
               end
            end
         end
         fwt_pkg::ST_FLUSH: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rlast_in = 1'b1;
               if (pend_ff) begin
                  rst_in  = pst_ff;
                  rpos_in = ppos_ff;
                  rbeg_in = pbeg_ff;
                  rend_in = pend_t_ff;
                  rdev_in = pdev_ff;
                  rtrk_in = ptrk_ff;
               end else begin
                  rst_in  = fwt_pkg::STATUS_NONE;
                  rpos_in = '0;
                  rbeg_in = '0;
                  rend_in = '0;
                  rdev_in = '0;
                  rtrk_in = '0;
               end
               state_in = fwt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fwt_pkg::ST_IDLE;
         end
      endcase
   end

   // Register port
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      tc_in   = tc_ff;
      host_in = host_ff;
      if (csr_wr && paddr == fwt_pkg::ADDR_TRACKS) begin
         tc_in = pwdata[fwt_pkg::TC_BITS-1:0];
      end
      if (csr_wr && paddr == fwt_pkg::ADDR_HOST) begin
         host_in = pwdata[7:0];
      end
   end

   always_comb begin
      case (paddr)
         fwt_pkg::ADDR_TRACKS: prdata = 32'(tc_ff);
         fwt_pkg::ADDR_HOST:   prdata = 32'(host_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwt_pkg::ST_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
         tc_ff    <= fwt_pkg::TRACKS_RESET;
         host_ff  <= '0;
         found_ff <= 1'b0;
         taken_ff <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         tc_ff    <= tc_in;
         host_ff  <= host_in;
         found_ff <= found_in;
         taken_ff <= taken_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      qs_ff        <= qs_in;
      qf_ff        <= qf_in;
      qdev_ff      <= qdev_in;
      qtrk_ff      <= qtrk_in;
      qidx_ff      <= qidx_in;
      lim_ff       <= lim_in;
      sel_ff       <= sel_in;
      car_begin_ff <= car_begin_in;
      car_end_ff   <= car_end_in;
      car_dev_ff   <= car_dev_in;
      car_trk_ff   <= car_trk_in;
      pst_ff       <= pst_in;
      ppos_ff      <= ppos_in;
      pbeg_ff      <= pbeg_in;
      pend_t_ff    <= pend_t_in;
      pdev_ff      <= pdev_in;
      ptrk_ff      <= ptrk_in;
      rst_ff       <= rst_in;
      rpos_ff      <= rpos_in;
      rbeg_ff      <= rbeg_in;
      rend_ff      <= rend_in;
      rdev_ff      <= rdev_in;
      rtrk_ff      <= rtrk_in;
      rlast_ff     <= rlast_in;
   end

   assign req_ready      = (state_ff == fwt_pkg::ST_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_status     = rst_ff;
   assign rsp_position   = rpos_ff;
   assign rsp_win_start  = rbeg_ff;
   assign rsp_win_stop   = rend_ff;
   assign rsp_win_device = rdev_ff;
   assign rsp_win_track  = rtrk_ff;
   assign rsp_last       = rlast_ff;

   `FWT_CHECK(a_count_bound, fwt_pkg::CMP_W'(cnt_ff) <= DEPTH_C)
   `FWT_CHECK_NEXT(a_one_item_at_a_time, req_valid && req_ready, !req_ready)
   `FWT_CHECK_NEXT(a_flush_closes_item, state_ff == fwt_pkg::ST_FLUSH && out_free,
                   rsp_valid && rsp_last && req_ready)
   `FWT_CHECK(a_walk_in_range, state_ff != fwt_pkg::ST_SCAN || kc < DEPTH_C)

endmodule

FILE: rtl/core/fwt_cell.sv
// ----------------------------------------------------------------------------
// Free window table cell
// Holds one table entry; loads its neighbor's entry on a shift or an open
// window on a rebuild.
// ----------------------------------------------------------------------------
module fwt_cell #(
   parameter int TIME_BITS   = fwt_pkg::DEF_TIME_BITS,
   parameter int DEVICE_BITS = fwt_pkg::DEF_DEVICE_BITS
) (
   input  logic                          clock,
   input  fwt_pkg::cell_ctrl_type        ctrl,
   input  logic [TIME_BITS-1:0]          in_begin,
   input  logic [TIME_BITS-1:0]          in_end,
   input  logic [DEVICE_BITS-1:0]        in_dev,
   input  logic [fwt_pkg::TRK_BITS-1:0]  in_trk,
   input  logic [DEVICE_BITS-1:0]        rb_dev,
   input  logic [fwt_pkg::TRK_BITS-1:0]  rb_trk,
   output logic [TIME_BITS-1:0]          out_begin,
   output logic [TIME_BITS-1:0]          out_end,
   output logic [DEVICE_BITS-1:0]        out_dev,
   output logic [fwt_pkg::TRK_BITS-1:0]  out_trk
);

   logic [TIME_BITS-1:0]         begin_ff, begin_in;
   logic [TIME_BITS-1:0]         end_ff, end_in;
   logic [DEVICE_BITS-1:0]       dev_ff, dev_in;
   logic [fwt_pkg::TRK_BITS-1:0] trk_ff, trk_in;

   always_comb begin
      begin_in = begin_ff;
      end_in   = end_ff;
      dev_in   = dev_ff;
      trk_in   = trk_ff;
      if (ctrl.rebuild) begin
         begin_in = '0;
         end_in   = '1;
         dev_in   = rb_dev;
         trk_in   = rb_trk;
      end else if (ctrl.shift) begin
         begin_in = in_begin;
         end_in   = in_end;
         dev_in   = in_dev;
         trk_in   = in_trk;
      end
   end

   always_ff @(posedge clock) begin
      begin_ff <= begin_in;
      end_ff   <= end_in;
      dev_ff   <= dev_in;
      trk_ff   <= trk_in;
   end

   assign out_begin = begin_ff;
   assign out_end   = end_ff;
   assign out_dev   = dev_ff;
   assign out_trk   = trk_ff;

endmodule

FILE: tb/sv/tb_free_window_table.sv
// ----------------------------------------------------------------------------
// Free window table testbench
// Drives rebuild, insert, remove and search requests with random sender gaps
// and receiver stalls, predicts every result transfer from a local copy of
// the table and compares each one field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_free_window_table;

   localparam int DEPTH = 16;
   localparam int TB = 48;
   localparam logic [TB-1:0] OPEN_END = {TB{1'b1}};
   localparam int WATCHDOG = 20000;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]    mode;
      logic [TB-1:0] t0;
      logic [TB-1:0] t1;
      logic [7:0]    dev;
      logic [5:0]    trk;
      logic [5:0]    idx;
      logic [5:0]    tasks;
   } request_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [5:0]    pos;
      logic [TB-1:0] b;
      logic [TB-1:0] e;
      logic [7:0]    dev;
      logic [5:0]    trk;
      logic          last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [2:0] req_mode = 0;
   logic [TB-1:0] req_time_start = 0, req_time_stop = 0;
   logic [7:0] req_device = 0;
   logic [5:0] req_track = 0, req_index = 0, req_task_count = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_position;
   logic [TB-1:0] rsp_win_start, rsp_win_stop;
   logic [7:0] rsp_win_device;
   logic [5:0] rsp_win_track;
   logic rsp_last;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   free_window_table uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Predicted table contents and registers.
   logic [TB-1:0] tab_b [DEPTH];
   logic [TB-1:0] tab_e [DEPTH];
   logic [7:0]    tab_d [DEPTH];
   logic [5:0]    tab_t [DEPTH];
   int            tab_n = 0;
   int            tracks = 4;
   logic [7:0]    host = 0;

   request_type pending_reqs[$];
   result_type  expected_results[$];
   int mismatches = 0, results_seen = 0, items_sent = 0, idle_cycles = 0;
   bit stim_done = 0;

   function automatic result_type entry_result(int i);
      result_type r;
      r = '{fwt_pkg::STATUS_OK, i[5:0], tab_b[i], tab_e[i], tab_d[i], tab_t[i], 1'b0};
      return r;
   endfunction

   function automatic result_type empty_result(logic [1:0] st);
      result_type r;
      r = '{st, 6'd0, '0, '0, 8'd0, 6'd0, 1'b0};
      return r;
   endfunction

   function automatic bit holds(int i, logic [TB-1:0] s, logic [TB-1:0] f);
      return tab_e[i] >= s && tab_b[i] <= s && tab_e[i] >= f;
   endfunction

   function automatic int sat_tracks();
      return tracks > DEPTH ? DEPTH : tracks;
   endfunction

   task automatic queue_req(request_type q);
      pending_reqs = {pending_reqs, q};
   endtask

   task automatic predict_window_op(request_type q);
      result_type outs[$];
      int p, lim, sel;
      bit picked;
      case (q.mode)
         fwt_pkg::MODE_REBUILD: begin
            tab_n = sat_tracks();
            for (int i = 0; i < tab_n; i++) begin
               tab_b[i] = '0; tab_e[i] = OPEN_END; tab_d[i] = host; tab_t[i] = 6'(i);
            end
            outs = {outs, empty_result(fwt_pkg::STATUS_OK)};
         end
         fwt_pkg::MODE_INSERT: begin
            if (tab_n >= DEPTH) outs = {outs, empty_result(fwt_pkg::STATUS_FULL)};
            else begin
               p = tab_n;
               for (int i = 0; i < tab_n; i++)
                  if (q.t1 < tab_e[i]) begin p = i; break; end
               for (int i = tab_n; i > p; i--) begin
                  tab_b[i] = tab_b[i-1]; tab_e[i] = tab_e[i-1];
                  tab_d[i] = tab_d[i-1]; tab_t[i] = tab_t[i-1];
               end
               tab_b[p] = q.t0; tab_e[p] = q.t1; tab_d[p] = q.dev; tab_t[p] = q.trk;
               tab_n++;
               outs = {outs, entry_result(p)};
            end
         end
         fwt_pkg::MODE_REMOVE: begin
            if (int'(q.idx) >= tab_n) outs = {outs, empty_result(fwt_pkg::STATUS_BADIDX)};
            else begin
               outs = {outs, entry_result(int'(q.idx))};
               for (int i = int'(q.idx); i + 1 < tab_n; i++) begin
                  tab_b[i] = tab_b[i+1]; tab_e[i] = tab_e[i+1];
                  tab_d[i] = tab_d[i+1]; tab_t[i] = tab_t[i+1];
               end
               tab_n--;
            end
         end
         fwt_pkg::MODE_CONTAIN, fwt_pkg::MODE_DEVICE: begin
            for (int i = 0; i < tab_n; i++) begin
               if (q.mode == fwt_pkg::MODE_DEVICE && tab_d[i] != q.dev) continue;
               if (holds(i, q.t0, q.t1)) begin outs = {outs, entry_result(i)}; break; end
            end
         end
         fwt_pkg::MODE_OVERLAP: begin
            picked = 0; sel = 0;
            for (int i = 0; i < tab_n; i++) begin
               if (picked && int'(tab_t[i]) != sel) continue;
               if (tab_b[i] < q.t1 && tab_e[i] > q.t0) begin
                  outs = {outs, entry_result(i)};
                  sel = int'(tab_t[i]); picked = 1;
               end
            end
         end
         fwt_pkg::MODE_MULTI: begin
            lim = sat_tracks();
            if (int'(q.tasks) < lim) lim = int'(q.tasks);
            for (int i = 0; i < tab_n && lim > 0; i++)
               if (holds(i, q.t0, q.t1)) begin outs = {outs, entry_result(i)}; lim--; end
         end
         default: ;
      endcase
      if (outs.size() == 0) outs = {outs, empty_result(fwt_pkg::STATUS_NONE)};
      outs[outs.size()-1].last = 1'b1;
      foreach (outs[k]) expected_results = {expected_results, outs[k]};
   endtask

   // Ready as seen at the last rising edge, so the driver knows if a transfer happened.
   logic req_ready_q = 0;
   always @(posedge clock) req_ready_q <= req_ready;

   // Driver: bursts of back-to-back transfers separated by random gaps.
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q) begin
            predict_window_op('{req_mode, req_time_start, req_time_stop, req_device,
                                req_track, req_index, req_task_count});
            items_sent++;
         end
         if (!(req_valid && !req_ready_q)) begin
            if (gap_left > 0) begin
               gap_left--; req_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
               request_type q;
               q = pending_reqs.pop_front();
               req_valid <= 1;
               req_mode <= q.mode; req_time_start <= q.t0; req_time_stop <= q.t1;
               req_device <= q.dev; req_track <= q.trk; req_index <= q.idx;
               req_task_count <= q.tasks;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = int'($urandom_range(0, 8));
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 20));
               end
            end else req_valid <= 0;
         end
         rsp_ready <= (results_seen % 50 < 15) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            result_type got, want;
            got = '{rsp_status, rsp_position, rsp_win_start, rsp_win_stop,
                    rsp_win_device, rsp_win_track, rsp_last};
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected %p got %p", results_seen, want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("free_window_table: mismatch");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == fwt_pkg::ADDR_TRACKS) tracks = int'(data[6:0]);
      else host = data[7:0];
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   function automatic logic [TB-1:0] rand_time();
      case ($urandom_range(0, 3))
         0: return TB'({$urandom, $urandom});
         1: return '0;
         2: return OPEN_END;
         default: return TB'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic request_type make_req(logic [2:0] m, logic [TB-1:0] a,
                                            logic [TB-1:0] z);
      request_type q;
      q = '{m, a, z, 8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)};
      return q;
   endfunction

   task automatic random_phase(int count);
      request_type q;
      logic [TB-1:0] a, z;
      for (int k = 0; k < count; k++) begin
         a = rand_time(); z = rand_time();
         if ($urandom_range(0, 3) != 0 && a > z) begin
            a = z; z = a + TB'($urandom_range(0, 500));
         end
         case ($urandom_range(0, 19))
            0: q = make_req(fwt_pkg::MODE_REBUILD, a, z);
            1, 2, 3, 4, 5: q = make_req(fwt_pkg::MODE_INSERT, a, z);
            6, 7, 8: q = make_req(fwt_pkg::MODE_REMOVE, a, z);
            9, 10: q = make_req(fwt_pkg::MODE_CONTAIN, a, z);
            11, 12: q = make_req(fwt_pkg::MODE_DEVICE, a, z);
            13, 14, 15: q = make_req(fwt_pkg::MODE_OVERLAP, a, z);
            16, 17, 18: q = make_req(fwt_pkg::MODE_MULTI, a, z);
            default: q = make_req(MODE_UNUSED, a, z);
         endcase
         if (q.mode == fwt_pkg::MODE_REMOVE && $urandom_range(0, 3) != 0)
            q.idx = 6'($urandom_range(0, 17));
         if (q.mode == fwt_pkg::MODE_DEVICE && $urandom_range(0, 1))
            q.dev = 8'($urandom_range(0, 3));
         if (q.mode == fwt_pkg::MODE_INSERT && $urandom_range(0, 1))
            q.dev = 8'($urandom_range(0, 3));
         queue_req(q);
      end
   endtask

   initial begin
      request_type q;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 0;
      // Directed part: empty-table queries, rebuild, extremes, full and bad index.
      queue_req(make_req(fwt_pkg::MODE_CONTAIN, '0, '0));
      q = make_req(fwt_pkg::MODE_REMOVE, '0, '0); q.idx = 0; queue_req(q);
      queue_req(make_req(fwt_pkg::MODE_REBUILD, '0, '0));
      q = make_req(fwt_pkg::MODE_MULTI, TB'(5), TB'(9)); q.tasks = 63; queue_req(q);
      q = make_req(fwt_pkg::MODE_MULTI, TB'(5), TB'(9)); q.tasks = 0; queue_req(q);
      q = make_req(fwt_pkg::MODE_INSERT, TB'(10), TB'(20));
      q.dev = 8'hFF; q.trk = 6'h3F; queue_req(q);
      q = make_req(fwt_pkg::MODE_INSERT, OPEN_END, OPEN_END); queue_req(q);
      q = make_req(fwt_pkg::MODE_INSERT, '0, '0); q.dev = 0; q.trk = 0; queue_req(q);
      queue_req(make_req(fwt_pkg::MODE_OVERLAP, '0, OPEN_END));
      q = make_req(fwt_pkg::MODE_DEVICE, TB'(12), TB'(15)); q.dev = 8'hFF; queue_req(q);
      queue_req(make_req(fwt_pkg::MODE_CONTAIN, TB'(12), TB'(25)));
      queue_req(make_req(MODE_UNUSED, '0, '0));
      for (int i = 0; i < 10; i++)
         queue_req(make_req(fwt_pkg::MODE_INSERT, TB'(i), TB'(100 + i)));
      queue_req(make_req(fwt_pkg::MODE_INSERT, TB'(1), TB'(2)));
      q = make_req(fwt_pkg::MODE_REMOVE, '0, '0); q.idx = 63; queue_req(q);
      q = make_req(fwt_pkg::MODE_REMOVE, '0, '0); q.idx = 15; queue_req(q);
      drain();
      // Random phases under different register settings, extremes included.
      csr_write(fwt_pkg::ADDR_TRACKS, 32'd1);  csr_write(fwt_pkg::ADDR_HOST, 32'd255);
      queue_req(make_req(fwt_pkg::MODE_REBUILD, '0, '0));
      random_phase(63); drain();
      csr_write(fwt_pkg::ADDR_TRACKS, 32'd127); csr_write(fwt_pkg::ADDR_HOST, 32'd0);
      queue_req(make_req(fwt_pkg::MODE_REBUILD, '0, '0));
      random_phase(63); drain();
      csr_write(fwt_pkg::ADDR_TRACKS, 32'd64); csr_write(fwt_pkg::ADDR_HOST, 32'd2);
      random_phase(63); drain();
      csr_write(fwt_pkg::ADDR_TRACKS, 32'd3); csr_write(fwt_pkg::ADDR_HOST, 32'd1);
      queue_req(make_req(fwt_pkg::MODE_REBUILD, '0, '0));
      random_phase(63); drain();
      $display("%0d requests sent, %0d result transfers checked over four register settings",
               items_sent, results_seen);
      if (mismatches == 0) $display("free_window_table: match");
      else begin
         $display("%0d mismatching result transfers", mismatches);
         $display("free_window_table: mismatch");
      end
      $finish;
   end

endmodule
